// File: hdl/c2i_pkg.sv
`default_nettype none

package c2i_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Configuration register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_LAYOUT_MODE   = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_STRIDE_H      = 3'd2,
    REG_STRIDE_W      = 3'd3,
    REG_DILATION_H    = 3'd4,
    REG_DILATION_W    = 3'd5,
    REG_PAD_H         = 3'd6,
    REG_PAD_W         = 3'd7
  } reg_idx_t;

  // Image store geometry and data width.
  localparam int STORE_DEPTH = 4096;
  localparam int STORE_AW    = 12;
  localparam int DATA_W      = 32;

  // Default geometry for the top-level parameters.
  localparam int IMG_H_DEF  = 16;
  localparam int IMG_W_DEF  = 16;
  localparam int GRID_H_DEF = 16;
  localparam int GRID_W_DEF = 16;
  localparam int KERN_H_DEF = 3;
  localparam int KERN_W_DEF = 3;

  // Live configuration as seen by the datapath.
  typedef struct packed {
    logic       layout_mode;
    logic [4:0] channel_count;
    logic [3:0] stride_h;
    logic [3:0] stride_w;
    logic [3:0] dilation_h;
    logic [3:0] dilation_w;
    logic [3:0] pad_h;
    logic [3:0] pad_w;
  } cfg_t;

  // One store request handed from the address pipeline to the accumulator.
  typedef struct packed {
    cmd_t                 cmd;
    logic [DATA_W-1:0]    value;
    logic [STORE_AW-1:0]  addr;
    logic                 inb;
    logic                 done;
  } req_t;

  // Channel count as used by the walk and the address: zero acts as one,
  // anything above sixteen acts as sixteen.
  function automatic logic [4:0] eff_channels(input logic [4:0] count);
    logic [4:0] res;
    res = count;
    if (count == 5'd0) begin
      res = 5'd1;
    end else if (count > 5'd16) begin
      res = 5'd16;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hdl/c2i_ram.sv
`default_nettype none

module c2i_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read of the word being written returns the old value.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/c2i_walk.sv
`default_nettype none

module c2i_walk #(
  parameter int KERN_H = c2i_pkg::KERN_H_DEF,
  parameter int KERN_W = c2i_pkg::KERN_W_DEF,
  parameter int GRID_H = c2i_pkg::GRID_H_DEF,
  parameter int GRID_W = c2i_pkg::GRID_W_DEF,
  localparam int KRW = (KERN_H > 1) ? $clog2(KERN_H) : 1,
  localparam int KCW = (KERN_W > 1) ? $clog2(KERN_W) : 1,
  localparam int GRW = (GRID_H > 1) ? $clog2(GRID_H) : 1,
  localparam int GCW = (GRID_W > 1) ? $clog2(GRID_W) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire c2i_pkg::cfg_t       cfg,
  input  wire logic                step,
  output logic      [3:0]          chan_pos,
  output logic      [KRW-1:0]      krow_pos,
  output logic      [KCW-1:0]      kcol_pos,
  output logic      [GRW-1:0]      grow_pos,
  output logic      [GCW-1:0]      gcol_pos,
  output logic                     done
);

  logic [4:0] ch_lim;
  logic       ch_wrap, kr_wrap, kc_wrap, gr_wrap, gc_wrap;
  logic       adv_gr, adv_kc, adv_kr, adv_ch;

  assign ch_lim = c2i_pkg::eff_channels(cfg.channel_count);

  // A position wraps when one more step would reach its limit.
  assign ch_wrap = ({1'b0, chan_pos} + 5'd1) >= ch_lim;
  assign kr_wrap = ({1'b0, krow_pos} + (KRW+1)'(1)) >= (KRW+1)'(KERN_H);
  assign kc_wrap = ({1'b0, kcol_pos} + (KCW+1)'(1)) >= (KCW+1)'(KERN_W);
  assign gr_wrap = ({1'b0, grow_pos} + (GRW+1)'(1)) >= (GRW+1)'(GRID_H);
  assign gc_wrap = ({1'b0, gcol_pos} + (GCW+1)'(1)) >= (GCW+1)'(GRID_W);

  // Carry chain; the order of the outer positions follows the layout.
  always_comb begin
    adv_gr = gc_wrap;
    if (cfg.layout_mode == 1'b0) begin
      adv_kc = gc_wrap & gr_wrap;
      adv_kr = adv_kc & kc_wrap;
      adv_ch = adv_kr & kr_wrap;
      done   = adv_ch & ch_wrap;
    end else begin
      adv_ch = gc_wrap & gr_wrap;
      adv_kc = adv_ch & ch_wrap;
      adv_kr = adv_kc & kc_wrap;
      done   = adv_kr & kr_wrap;
    end
  end

  // Position registers advance on every push.
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_pos <= '0;
      krow_pos <= '0;
      kcol_pos <= '0;
      grow_pos <= '0;
      gcol_pos <= '0;
    end else if (step) begin
      gcol_pos <= gc_wrap ? '0 : gcol_pos + GCW'(1);
      if (adv_gr) begin
        grow_pos <= gr_wrap ? '0 : grow_pos + GRW'(1);
      end
      if (adv_kc) begin
        kcol_pos <= kc_wrap ? '0 : kcol_pos + KCW'(1);
      end
      if (adv_kr) begin
        krow_pos <= kr_wrap ? '0 : krow_pos + KRW'(1);
      end
      if (adv_ch) begin
        chan_pos <= ch_wrap ? '0 : chan_pos + 4'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/c2i_addr.sv
`default_nettype none

module c2i_addr #(
  parameter int IMG_H  = c2i_pkg::IMG_H_DEF,
  parameter int IMG_W  = c2i_pkg::IMG_W_DEF,
  parameter int KERN_H = c2i_pkg::KERN_H_DEF,
  parameter int KERN_W = c2i_pkg::KERN_W_DEF,
  parameter int GRID_H = c2i_pkg::GRID_H_DEF,
  parameter int GRID_W = c2i_pkg::GRID_W_DEF,
  localparam int KRW = (KERN_H > 1) ? $clog2(KERN_H) : 1,
  localparam int KCW = (KERN_W > 1) ? $clog2(KERN_W) : 1,
  localparam int GRW = (GRID_H > 1) ? $clog2(GRID_H) : 1,
  localparam int GCW = (GRID_W > 1) ? $clog2(GRID_W) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire c2i_pkg::cfg_t                     cfg,
  // Accepted input transaction and the walk position it carries.
  input  wire logic                              accept,
  output logic                                   a_free,
  input  wire c2i_pkg::cmd_t                     cmd,
  input  wire logic [c2i_pkg::DATA_W-1:0]        value,
  input  wire logic [c2i_pkg::STORE_AW-1:0]      waddr,
  input  wire logic [3:0]                        chan_pos,
  input  wire logic [KRW-1:0]                    krow_pos,
  input  wire logic [KCW-1:0]                    kcol_pos,
  input  wire logic [GRW-1:0]                    grow_pos,
  input  wire logic [GCW-1:0]                    gcol_pos,
  input  wire logic                              done,
  // Request toward the accumulator; the store read is issued as it moves.
  output logic                                   req_valid,
  input  wire logic                              req_ready,
  output c2i_pkg::req_t                          req,
  output logic                                   rd_en,
  output logic      [c2i_pkg::STORE_AW-1:0]      rd_addr
);

  localparam int MXW  = (KRW > GRW) ? KRW : GRW;
  localparam int MYW  = (KCW > GCW) ? KCW : GCW;
  localparam int IHW0 = MXW + 6;
  localparam int IWW0 = MYW + 6;
  localparam int IHW  = (IHW0 > 8) ? IHW0 : 8;
  localparam int IWW  = (IWW0 > 8) ? IWW0 : 8;
  localparam int ROWW = (IMG_H > 1) ? $clog2(IMG_H) : 1;
  localparam int COLW = (IMG_W > 1) ? $clog2(IMG_W) : 1;
  localparam int PIXW = (IMG_H * IMG_W > 1) ? $clog2(IMG_H * IMG_W) : 1;
  localparam int AFW  = $clog2(16 * IMG_H * IMG_W);

  // Image row and column of the element being accepted.
  logic        [KRW+3:0] kr_prod;
  logic        [GRW+3:0] gr_prod;
  logic        [KCW+3:0] kc_prod;
  logic        [GCW+3:0] gc_prod;
  logic signed [IHW-1:0] ih_c;
  logic signed [IWW-1:0] iw_c;

  assign kr_prod = (KRW+4)'(krow_pos) * (KRW+4)'(cfg.dilation_h);
  assign gr_prod = (GRW+4)'(grow_pos) * (GRW+4)'(cfg.stride_h);
  assign kc_prod = (KCW+4)'(kcol_pos) * (KCW+4)'(cfg.dilation_w);
  assign gc_prod = (GCW+4)'(gcol_pos) * (GCW+4)'(cfg.stride_w);
  assign ih_c = $signed(IHW'(kr_prod)) + $signed(IHW'(gr_prod)) - $signed(IHW'(cfg.pad_h));
  assign iw_c = $signed(IWW'(kc_prod)) + $signed(IWW'(gc_prod)) - $signed(IWW'(cfg.pad_w));

  // First stage: transaction plus image row and column.
  logic                              a_valid;
  c2i_pkg::cmd_t                     a_cmd;
  logic [c2i_pkg::DATA_W-1:0]        a_value;
  logic [c2i_pkg::STORE_AW-1:0]      a_waddr;
  logic                              a_done;
  logic [3:0]                        a_chan;
  logic signed [IHW-1:0]             a_ih;
  logic signed [IWW-1:0]             a_iw;

  // Second stage: bounds check and pixel index inside one channel plane.
  logic                              b_valid;
  c2i_pkg::cmd_t                     b_cmd;
  logic [c2i_pkg::DATA_W-1:0]        b_value;
  logic [c2i_pkg::STORE_AW-1:0]      b_waddr;
  logic                              b_done;
  logic [3:0]                        b_chan;
  logic                              b_inb;
  logic [PIXW-1:0]                   b_pix;

  logic            move_a, move_b, b_free;
  logic            inb_c;
  logic [PIXW-1:0] pix_c;

  assign move_b = b_valid & req_ready;
  assign b_free = ~b_valid | move_b;
  assign move_a = a_valid & b_free;
  assign a_free = ~a_valid | move_a;

  assign inb_c = ~a_ih[IHW-1] && (a_ih < $signed(IHW'(IMG_H))) &&
                 ~a_iw[IWW-1] && (a_iw < $signed(IWW'(IMG_W)));
  assign pix_c = PIXW'(a_ih[ROWW-1:0]) * PIXW'(IMG_W) + PIXW'(a_iw[COLW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (move_a) begin
        a_valid <= 1'b0;
      end
      if (move_a) begin
        b_valid <= 1'b1;
      end else if (move_b) begin
        b_valid <= 1'b0;
      end
    end
    if (accept) begin
      a_cmd   <= cmd;
      a_value <= value;
      a_waddr <= waddr;
      a_done  <= done;
      a_chan  <= chan_pos;
      a_ih    <= ih_c;
      a_iw    <= iw_c;
    end
    if (move_a) begin
      b_cmd   <= a_cmd;
      b_value <= a_value;
      b_waddr <= a_waddr;
      b_done  <= a_done;
      b_chan  <= a_chan;
      b_inb   <= inb_c;
      b_pix   <= pix_c;
    end
  end

  // Store address for the layout; positions past the store are dropped.
  logic [4:0]     ch_lim;
  logic [AFW-1:0] addr_full;
  logic           fits;

  assign ch_lim = c2i_pkg::eff_channels(cfg.channel_count);

  always_comb begin
    if (cfg.layout_mode == 1'b0) begin
      addr_full = AFW'(b_chan) * AFW'(IMG_H * IMG_W) + AFW'(b_pix);
    end else begin
      addr_full = AFW'(b_pix) * AFW'(ch_lim) + AFW'(b_chan);
    end
    fits = 32'(addr_full) < 32'(c2i_pkg::STORE_DEPTH);
  end

  // Request to the accumulator.
  always_comb begin
    req.cmd   = b_cmd;
    req.value = b_value;
    req.done  = 1'b0;
    req.inb   = 1'b0;
    req.addr  = b_waddr;
    if (b_cmd == c2i_pkg::CMD_PUSH) begin
      req.done = b_done;
      req.inb  = b_inb & fits;
      req.addr = (b_inb & fits) ? c2i_pkg::STORE_AW'(addr_full) : '0;
    end
  end

  assign req_valid = b_valid;
  assign rd_en     = move_b;
  assign rd_addr   = req.addr;

endmodule

`default_nettype wire

// File: hdl/c2i_accum.sv
`default_nettype none

module c2i_accum (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Request from the address pipeline and the word read for it.
  input  wire logic                              req_valid,
  output logic                                   req_ready,
  input  wire c2i_pkg::req_t                     req,
  input  wire logic [c2i_pkg::DATA_W-1:0]        rdata,
  // Write-back into the store.
  output logic                                   we,
  output logic      [c2i_pkg::STORE_AW-1:0]      waddr,
  output logic      [c2i_pkg::DATA_W-1:0]        wdata,
  // Result transaction.
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [c2i_pkg::STORE_AW-1:0]      image_addr,
  output logic                                   in_bounds,
  output logic signed [c2i_pkg::DATA_W-1:0]      word_data,
  output logic                                   frame_done,
  output logic                                   saturated
);

  logic                              d_valid;
  c2i_pkg::req_t                     d_req;
  logic                              move_d;

  // Last word written, forwarded when the store read was too early to see it.
  logic                              wb_valid;
  logic [c2i_pkg::STORE_AW-1:0]      wb_addr;
  logic [c2i_pkg::DATA_W-1:0]        wb_data;

  logic [c2i_pkg::DATA_W-1:0]        old_word;
  logic signed [c2i_pkg::DATA_W:0]   sum;
  logic                              sat_hi, sat_lo;
  logic [c2i_pkg::DATA_W-1:0]        sum_sat;

  assign move_d    = d_valid & (~out_valid | out_ready);
  assign req_ready = ~d_valid | move_d;

  assign old_word = (wb_valid && (wb_addr == d_req.addr)) ? wb_data : rdata;

  // Saturating add in Q16.16.
  assign sum     = $signed({old_word[c2i_pkg::DATA_W-1], old_word}) +
                   $signed({d_req.value[c2i_pkg::DATA_W-1], d_req.value});
  assign sat_hi  = ~sum[c2i_pkg::DATA_W] &  sum[c2i_pkg::DATA_W-1];
  assign sat_lo  =  sum[c2i_pkg::DATA_W] & ~sum[c2i_pkg::DATA_W-1];
  assign sum_sat = sat_hi ? {1'b0, {(c2i_pkg::DATA_W-1){1'b1}}} :
                   sat_lo ? {1'b1, {(c2i_pkg::DATA_W-1){1'b0}}} :
                   sum[c2i_pkg::DATA_W-1:0];

  // Write-back happens as the request leaves this stage.
  always_comb begin
    we    = 1'b0;
    waddr = d_req.addr;
    wdata = '0;
    if (move_d) begin
      case (d_req.cmd)
        c2i_pkg::CMD_PUSH: begin
          we    = d_req.inb;
          wdata = sum_sat;
        end
        c2i_pkg::CMD_CLEAR: begin
          we = 1'b1;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
      wb_valid  <= 1'b0;
    end else begin
      if (req_valid & req_ready) begin
        d_valid <= 1'b1;
      end else if (move_d) begin
        d_valid <= 1'b0;
      end
      if (move_d) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (we) begin
        wb_valid <= 1'b1;
      end
    end
    if (req_valid & req_ready) begin
      d_req <= req;
    end
    if (we) begin
      wb_addr <= waddr;
      wb_data <= wdata;
    end
    // Result fields per command.
    if (move_d) begin
      image_addr <= '0;
      in_bounds  <= 1'b0;
      word_data  <= '0;
      frame_done <= 1'b0;
      saturated  <= 1'b0;
      case (d_req.cmd)
        c2i_pkg::CMD_PUSH: begin
          frame_done <= d_req.done;
          if (d_req.inb) begin
            image_addr <= d_req.addr;
            in_bounds  <= 1'b1;
            word_data  <= $signed(sum_sat);
            saturated  <= sat_hi | sat_lo;
          end
        end
        c2i_pkg::CMD_READ: begin
          image_addr <= d_req.addr;
          word_data  <= $signed(old_word);
        end
        c2i_pkg::CMD_CLEAR: begin
          image_addr <= d_req.addr;
        end
        default: begin
          image_addr <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/col2im_scatter_accumulate_top.sv
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_ready    command, col_value, word_addr
// result    out_valid / out_ready  image_addr, in_bounds, word_data, frame_done, saturated
// config    psel / penable / pwrite / pready   paddr, pwdata, prdata
//
// One transaction is accepted per cycle while in_ready is high, and each gives one result
// through address stages a and b, the accumulator stage and the result register. The rate
// is set by the single store read-modify-write per item, with the last written word
// forwarded to cover a read that overlaps the write. After reset the store is cleared one
// word a cycle; in_ready is low meanwhile, and configuration writes are taken as usual.
// A stalled result holds its stage; items upstream keep moving into empty stages.
module col2im_scatter_accumulate_top #(
  parameter int IMG_H  = c2i_pkg::IMG_H_DEF,
  parameter int IMG_W  = c2i_pkg::IMG_W_DEF,
  parameter int GRID_H = c2i_pkg::GRID_H_DEF,
  parameter int GRID_W = c2i_pkg::GRID_W_DEF,
  parameter int KERN_H = c2i_pkg::KERN_H_DEF,
  parameter int KERN_W = c2i_pkg::KERN_W_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [4:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  // Input channel.
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        command,
  input  wire logic signed [c2i_pkg::DATA_W-1:0] col_value,
  input  wire logic [c2i_pkg::STORE_AW-1:0]      word_addr,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [c2i_pkg::STORE_AW-1:0]      image_addr,
  output logic                                   in_bounds,
  output logic signed [c2i_pkg::DATA_W-1:0]      word_data,
  output logic                                   frame_done,
  output logic                                   saturated
);

  localparam int KRW = (KERN_H > 1) ? $clog2(KERN_H) : 1;
  localparam int KCW = (KERN_W > 1) ? $clog2(KERN_W) : 1;
  localparam int GRW = (GRID_H > 1) ? $clog2(GRID_H) : 1;
  localparam int GCW = (GRID_W > 1) ? $clog2(GRID_W) : 1;

  // Configuration registers.
  c2i_pkg::cfg_t     cfg;
  c2i_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = c2i_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layout_mode   <= 1'b0;
      cfg.channel_count <= 5'd1;
      cfg.stride_h      <= 4'd1;
      cfg.stride_w      <= 4'd1;
      cfg.dilation_h    <= 4'd1;
      cfg.dilation_w    <= 4'd1;
      cfg.pad_h         <= 4'd0;
      cfg.pad_w         <= 4'd0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        c2i_pkg::REG_LAYOUT_MODE:   cfg.layout_mode   <= pwdata[0];
        c2i_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[4:0];
        c2i_pkg::REG_STRIDE_H:      cfg.stride_h      <= pwdata[3:0];
        c2i_pkg::REG_STRIDE_W:      cfg.stride_w      <= pwdata[3:0];
        c2i_pkg::REG_DILATION_H:    cfg.dilation_h    <= pwdata[3:0];
        c2i_pkg::REG_DILATION_W:    cfg.dilation_w    <= pwdata[3:0];
        c2i_pkg::REG_PAD_H:         cfg.pad_h         <= pwdata[3:0];
        c2i_pkg::REG_PAD_W:         cfg.pad_w         <= pwdata[3:0];
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      c2i_pkg::REG_LAYOUT_MODE:   prdata = 32'(cfg.layout_mode);
      c2i_pkg::REG_CHANNEL_COUNT: prdata = 32'(cfg.channel_count);
      c2i_pkg::REG_STRIDE_H:      prdata = 32'(cfg.stride_h);
      c2i_pkg::REG_STRIDE_W:      prdata = 32'(cfg.stride_w);
      c2i_pkg::REG_DILATION_H:    prdata = 32'(cfg.dilation_h);
      c2i_pkg::REG_DILATION_W:    prdata = 32'(cfg.dilation_w);
      c2i_pkg::REG_PAD_H:         prdata = 32'(cfg.pad_h);
      c2i_pkg::REG_PAD_W:         prdata = 32'(cfg.pad_w);
    endcase
  end

  // Clearing pass over the store after reset.
  logic [c2i_pkg::STORE_AW:0] clr_cnt;
  logic                       clearing;

  assign clearing = ~clr_cnt[c2i_pkg::STORE_AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + (c2i_pkg::STORE_AW+1)'(1);
    end
  end

  // Input acceptance and the column walk.
  c2i_pkg::cmd_t   cmd;
  logic            a_free;
  logic            accept;
  logic            step;
  logic [3:0]      chan_pos;
  logic [KRW-1:0]  krow_pos;
  logic [KCW-1:0]  kcol_pos;
  logic [GRW-1:0]  grow_pos;
  logic [GCW-1:0]  gcol_pos;
  logic            walk_done;

  assign cmd      = c2i_pkg::cmd_t'(command);
  assign in_ready = a_free & ~clearing;
  assign accept   = in_valid & in_ready;
  assign step     = accept & (cmd == c2i_pkg::CMD_PUSH);

  c2i_walk #(
    .KERN_H (KERN_H),
    .KERN_W (KERN_W),
    .GRID_H (GRID_H),
    .GRID_W (GRID_W)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .step     (step),
    .chan_pos (chan_pos),
    .krow_pos (krow_pos),
    .kcol_pos (kcol_pos),
    .grow_pos (grow_pos),
    .gcol_pos (gcol_pos),
    .done     (walk_done)
  );

  // Address pipeline.
  logic                         req_valid;
  logic                         req_ready;
  c2i_pkg::req_t                req;
  logic                         rd_en;
  logic [c2i_pkg::STORE_AW-1:0] rd_addr;

  c2i_addr #(
    .IMG_H  (IMG_H),
    .IMG_W  (IMG_W),
    .KERN_H (KERN_H),
    .KERN_W (KERN_W),
    .GRID_H (GRID_H),
    .GRID_W (GRID_W)
  ) u_addr (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .a_free    (a_free),
    .cmd       (cmd),
    .value     (col_value),
    .waddr     (word_addr),
    .chan_pos  (chan_pos),
    .krow_pos  (krow_pos),
    .kcol_pos  (kcol_pos),
    .grow_pos  (grow_pos),
    .gcol_pos  (gcol_pos),
    .done      (walk_done),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  // Accumulator and result register.
  logic                         acc_we;
  logic [c2i_pkg::STORE_AW-1:0] acc_waddr;
  logic [c2i_pkg::DATA_W-1:0]   acc_wdata;
  logic [c2i_pkg::DATA_W-1:0]   rdata;

  c2i_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rdata      (rdata),
    .we         (acc_we),
    .waddr      (acc_waddr),
    .wdata      (acc_wdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .image_addr (image_addr),
    .in_bounds  (in_bounds),
    .word_data  (word_data),
    .frame_done (frame_done),
    .saturated  (saturated)
  );

  // Image store; the clearing pass owns the write port until it finishes.
  logic                         ram_we;
  logic [c2i_pkg::STORE_AW-1:0] ram_waddr;
  logic [c2i_pkg::DATA_W-1:0]   ram_wdata;

  assign ram_we    = clearing | acc_we;
  assign ram_waddr = clearing ? clr_cnt[c2i_pkg::STORE_AW-1:0] : acc_waddr;
  assign ram_wdata = clearing ? '0 : acc_wdata;

  c2i_ram #(
    .WIDTH (c2i_pkg::DATA_W),
    .DEPTH (c2i_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

// One result transaction as the block should present it.
typedef struct packed {
  logic [c2i_pkg::STORE_AW-1:0] image_addr;
  logic                         in_bounds;
  logic [c2i_pkg::DATA_W-1:0]   word_data;
  logic                         frame_done;
  logic                         saturated;
} scatter_result_t;

// Shadow of the scatter walk and the image store, plus the queue of results still owed.
class scatter_scoreboard;
  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;
  localparam int MAX_PRINTED = 100;

  logic [c2i_pkg::DATA_W-1:0]   image_words [c2i_pkg::STORE_DEPTH];
  int                           chan_pos, krow_pos, kcol_pos, grow_pos, gcol_pos;
  c2i_pkg::cfg_t                cfg;
  scatter_result_t              owed_results[$];
  int                           errors;
  bit                           frame_wrapped;
  logic [c2i_pkg::STORE_AW-1:0] last_addr;

  function new();
    foreach (image_words[i]) image_words[i] = '0;
    chan_pos = 0;
    krow_pos = 0;
    kcol_pos = 0;
    grow_pos = 0;
    gcol_pos = 0;
    cfg = '{layout_mode: 1'b0, channel_count: 5'd1, stride_h: 4'd1, stride_w: 4'd1,
            dilation_h: 4'd1, dilation_w: 4'd1, pad_h: 4'd0, pad_w: 4'd0};
    errors = 0;
    frame_wrapped = 1'b0;
    last_addr = '0;
  endfunction

  function int pending();
    return owed_results.size();
  endfunction

  // Mirror one register write.
  function void set_register(c2i_pkg::reg_idx_t idx, logic [31:0] value);
    case (idx)
      c2i_pkg::REG_LAYOUT_MODE:   cfg.layout_mode   = value[0];
      c2i_pkg::REG_CHANNEL_COUNT: cfg.channel_count = value[4:0];
      c2i_pkg::REG_STRIDE_H:      cfg.stride_h      = value[3:0];
      c2i_pkg::REG_STRIDE_W:      cfg.stride_w      = value[3:0];
      c2i_pkg::REG_DILATION_H:    cfg.dilation_h    = value[3:0];
      c2i_pkg::REG_DILATION_W:    cfg.dilation_w    = value[3:0];
      c2i_pkg::REG_PAD_H:         cfg.pad_h         = value[3:0];
      c2i_pkg::REG_PAD_W:         cfg.pad_w         = value[3:0];
      default: ;
    endcase
  endfunction

  // A channel count of zero acts as one; anything past sixteen acts as sixteen.
  function int channels();
    if (cfg.channel_count == 0) return 1;
    if (cfg.channel_count > 16) return 16;
    return cfg.channel_count;
  endfunction

  // Step one walk position; returns 1 when it wraps and carries outward.
  function bit bump(inout int pos, input int limit);
    if (pos + 1 >= limit) begin
      pos = 0;
      return 1'b1;
    end
    pos = pos + 1;
    return 1'b0;
  endfunction

  // Advance the walk in the current layout order; returns 1 at the end of a frame.
  function bit advance_walk();
    int nch;
    nch = channels();
    if (!bump(gcol_pos, c2i_pkg::GRID_W_DEF)) return 1'b0;
    if (!bump(grow_pos, c2i_pkg::GRID_H_DEF)) return 1'b0;
    if (!cfg.layout_mode) begin
      if (!bump(kcol_pos, c2i_pkg::KERN_W_DEF)) return 1'b0;
      if (!bump(krow_pos, c2i_pkg::KERN_H_DEF)) return 1'b0;
      return bump(chan_pos, nch);
    end
    if (!bump(chan_pos, nch)) return 1'b0;
    if (!bump(kcol_pos, c2i_pkg::KERN_W_DEF)) return 1'b0;
    return bump(krow_pos, c2i_pkg::KERN_H_DEF);
  endfunction

  // Work out the result of one accepted input transaction and queue it.
  function void note_transaction(c2i_pkg::cmd_t cmd, logic [31:0] value,
                                 logic [c2i_pkg::STORE_AW-1:0] waddr);
    scatter_result_t r;
    int ih, iw, a, dh, dw, sh, sw, ph, pw;
    longint sum;
    r = '0;
    case (cmd)
      c2i_pkg::CMD_PUSH: begin
        dh = cfg.dilation_h;
        dw = cfg.dilation_w;
        sh = cfg.stride_h;
        sw = cfg.stride_w;
        ph = cfg.pad_h;
        pw = cfg.pad_w;
        ih = krow_pos * dh - ph + grow_pos * sh;
        iw = kcol_pos * dw - pw + gcol_pos * sw;
        if (ih >= 0 && ih < c2i_pkg::IMG_H_DEF && iw >= 0 && iw < c2i_pkg::IMG_W_DEF) begin
          if (cfg.layout_mode) begin
            a = (ih * c2i_pkg::IMG_W_DEF + iw) * channels() + chan_pos;
          end else begin
            a = chan_pos * c2i_pkg::IMG_H_DEF * c2i_pkg::IMG_W_DEF +
                ih * c2i_pkg::IMG_W_DEF + iw;
          end
          // Positions past the end of the store are dropped like out-of-image ones.
          if (a < c2i_pkg::STORE_DEPTH) begin
            sum = longint'($signed(image_words[a])) + longint'($signed(value));
            if (sum > SUM_MAX) begin
              sum = SUM_MAX;
              r.saturated = 1'b1;
            end
            if (sum < SUM_MIN) begin
              sum = SUM_MIN;
              r.saturated = 1'b1;
            end
            image_words[a] = sum[31:0];
            r.image_addr = a[c2i_pkg::STORE_AW-1:0];
            r.in_bounds = 1'b1;
            r.word_data = sum[31:0];
            last_addr = a[c2i_pkg::STORE_AW-1:0];
          end
        end
        // The walk moves on even for a dropped value.
        frame_wrapped = advance_walk();
        r.frame_done = frame_wrapped;
      end
      c2i_pkg::CMD_READ: begin
        r.image_addr = waddr;
        r.word_data = image_words[waddr];
      end
      c2i_pkg::CMD_CLEAR: begin
        image_words[waddr] = '0;
        r.image_addr = waddr;
      end
      default: ;
    endcase
    owed_results.push_back(r);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Compare one result transaction with the oldest one owed.
  task check_result(logic [c2i_pkg::STORE_AW-1:0] addr, logic inb,
                    logic [c2i_pkg::DATA_W-1:0] data, logic done, logic sat);
    scatter_result_t exp;
    if (owed_results.size() == 0) begin
      report($sformatf("result with nothing owed (addr %0h data %0h)", addr, data));
      return;
    end
    exp = owed_results.pop_front();
    if (addr !== exp.image_addr)
      report($sformatf("image_addr %0h, expected %0h", addr, exp.image_addr));
    if (inb !== exp.in_bounds)
      report($sformatf("in_bounds %b, expected %b", inb, exp.in_bounds));
    if (data !== exp.word_data)
      report($sformatf("word_data %0h, expected %0h", data, exp.word_data));
    if (done !== exp.frame_done)
      report($sformatf("frame_done %b, expected %b", done, exp.frame_done));
    if (sat !== exp.saturated)
      report($sformatf("saturated %b, expected %b", sat, exp.saturated));
  endtask
endclass

module tb;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PHASES  = 12;

  logic                                clk;
  logic                                rst;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [4:0]                          paddr;
  logic [31:0]                         pwdata;
  logic [31:0]                         prdata;
  logic                                pready;
  logic                                in_valid;
  logic                                in_ready;
  logic [1:0]                          command;
  logic signed [c2i_pkg::DATA_W-1:0]   col_value;
  logic [c2i_pkg::STORE_AW-1:0]        word_addr;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [c2i_pkg::STORE_AW-1:0]        image_addr;
  logic                                in_bounds;
  logic signed [c2i_pkg::DATA_W-1:0]   word_data;
  logic                                frame_done;
  logic                                saturated;

  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;

  scatter_scoreboard sb = new();

  col2im_scatter_accumulate_top DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: check each accepted result transaction, then pick the next ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result(image_addr, in_bounds, word_data, frame_done, saturated);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one input transaction, with a random gap first, and hold it until taken.
  task automatic send_item(input c2i_pkg::cmd_t c, input logic [31:0] v,
                           input logic [c2i_pkg::STORE_AW-1:0] a);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      col_value <= $urandom;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    command <= c;
    col_value <= v;
    word_addr <= a;
    do @(posedge clk); while (!in_ready);
    sb.note_transaction(c, v, a);
  endtask

  // Stop sending until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write all registers through the configuration port, back to back.
  task automatic write_config(input c2i_pkg::cfg_t c);
    logic [31:0]       v;
    c2i_pkg::reg_idx_t idx;
    for (int i = 0; i <= int'(c2i_pkg::REG_PAD_W); i++) begin
      idx = c2i_pkg::reg_idx_t'(i);
      case (idx)
        c2i_pkg::REG_LAYOUT_MODE:   v = 32'(c.layout_mode);
        c2i_pkg::REG_CHANNEL_COUNT: v = 32'(c.channel_count);
        c2i_pkg::REG_STRIDE_H:      v = 32'(c.stride_h);
        c2i_pkg::REG_STRIDE_W:      v = 32'(c.stride_w);
        c2i_pkg::REG_DILATION_H:    v = 32'(c.dilation_h);
        c2i_pkg::REG_DILATION_W:    v = 32'(c.dilation_w);
        c2i_pkg::REG_PAD_H:         v = 32'(c.pad_h);
        default:                    v = 32'(c.pad_w);
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      sb.set_register(idx, v);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic reconfigure(input c2i_pkg::cfg_t c);
    drain_results();
    write_config(c);
  endtask

  // Values: full range, small Q16.16 numbers, the limits, and shifted positives.
  function automatic logic [31:0] rand_value();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return $urandom;
    if (pick == 1) return int'($urandom_range(0, 262143)) - 131072;
    if (pick == 2) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom >> $urandom_range(0, 31);
  endfunction

  // Mostly small geometry so that many pushes land, with the full range now and then.
  function automatic logic [3:0] rand_geom(input int small_max);
    if ($urandom_range(0, 3) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, small_max));
  endfunction

  function automatic c2i_pkg::cfg_t rand_config();
    c2i_pkg::cfg_t c;
    c.layout_mode = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: c.channel_count = 5'd0;
      1: c.channel_count = 5'd16;
      2: c.channel_count = 5'($urandom_range(17, 31));
      default: c.channel_count = 5'($urandom_range(1, 4));
    endcase
    c.stride_h = rand_geom(3);
    c.stride_w = rand_geom(3);
    c.dilation_h = rand_geom(2);
    c.dilation_w = rand_geom(2);
    c.pad_h = rand_geom(2);
    c.pad_w = rand_geom(2);
    return c;
  endfunction

  // Mostly pushes; reads and clears often aim at the word last accumulated.
  task automatic run_random_phase(input int n);
    c2i_pkg::cmd_t                c;
    int                           r;
    logic [c2i_pkg::STORE_AW-1:0] a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) c = c2i_pkg::CMD_PUSH;
      else if (r < 85) c = c2i_pkg::CMD_READ;
      else if (r < 95) c = c2i_pkg::CMD_CLEAR;
      else c = c2i_pkg::CMD_NOP;
      if (c != c2i_pkg::CMD_PUSH && $urandom_range(0, 1) == 1) a = sb.last_addr;
      else a = c2i_pkg::STORE_AW'($urandom_range(0, c2i_pkg::STORE_DEPTH - 1));
      if ($urandom_range(0, 99) == 0) drain_results();
      send_item(c, rand_value(), a);
    end
  endtask

  task automatic run_directed();
    c2i_pkg::cfg_t c;
    // Zero stride, dilation and padding pile every push onto word zero:
    // overflow in both directions, then read, clear and no-operation traffic.
    c = '{layout_mode: 1'b0, channel_count: 5'd1, stride_h: 4'd0, stride_w: 4'd0,
          dilation_h: 4'd0, dilation_w: 4'd0, pad_h: 4'd0, pad_w: 4'd0};
    reconfigure(c);
    send_item(c2i_pkg::CMD_PUSH, 32'h7FFF_FFFF, 12'h000);
    send_item(c2i_pkg::CMD_PUSH, 32'h0000_0001, 12'hFFF);
    send_item(c2i_pkg::CMD_PUSH, 32'h8000_0000, 12'h000);
    send_item(c2i_pkg::CMD_PUSH, 32'h8000_0000, 12'h000);
    send_item(c2i_pkg::CMD_PUSH, 32'hFFFF_FFFF, 12'h000);
    send_item(c2i_pkg::CMD_READ, 32'h0000_0000, 12'h000);
    send_item(c2i_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 12'h000);
    send_item(c2i_pkg::CMD_READ, 32'h0000_0000, 12'h000);
    send_item(c2i_pkg::CMD_NOP, 32'hA5A5_5A5A, 12'hABC);
    send_item(c2i_pkg::CMD_CLEAR, 32'h0000_0000, 12'hFFF);
    send_item(c2i_pkg::CMD_READ, 32'h0000_0000, 12'hFFF);
    send_item(c2i_pkg::CMD_PUSH, 32'h0001_0000, 12'h000);
    send_item(c2i_pkg::CMD_READ, 32'h0000_0000, 12'h000);

    // Maximum geometry with an oversized channel count: the pushes fall off the image.
    c = '{layout_mode: 1'b1, channel_count: 5'd31, stride_h: 4'd15, stride_w: 4'd15,
          dilation_h: 4'd15, dilation_w: 4'd15, pad_h: 4'd15, pad_w: 4'd15};
    reconfigure(c);
    repeat (4) send_item(c2i_pkg::CMD_PUSH, rand_value(), 12'hFFF);

    // Sixteen channels, unit geometry, changed part way through a frame.
    c = '{layout_mode: 1'b0, channel_count: 5'd16, stride_h: 4'd1, stride_w: 4'd1,
          dilation_h: 4'd1, dilation_w: 4'd1, pad_h: 4'd0, pad_w: 4'd0};
    reconfigure(c);
    repeat (5) send_item(c2i_pkg::CMD_PUSH, rand_value(), 12'h000);
    send_item(c2i_pkg::CMD_READ, 32'h0000_0000, sb.last_addr);
  endtask

  // Test sequence.
  initial begin
    c2i_pkg::cfg_t c;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    command <= c2i_pkg::CMD_NOP;
    col_value <= '0;
    word_addr <= '0;
    send_idle_pct = 25;
    recv_idle_pct = 70;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // Swap the idle pattern after a third of the run, and drop it after two thirds.
      if (p == RANDOM_PHASES / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 25;
      end
      if (p == 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0) begin
        c = '{layout_mode: 1'b1, channel_count: 5'd31, stride_h: 4'd15, stride_w: 4'd15,
              dilation_h: 4'd15, dilation_w: 4'd15, pad_h: 4'd15, pad_w: 4'd15};
      end else if (p == 1) begin
        c = '{layout_mode: 1'b0, channel_count: 5'd0, stride_h: 4'd0, stride_w: 4'd0,
              dilation_h: 4'd0, dilation_w: 4'd0, pad_h: 4'd0, pad_w: 4'd0};
      end else begin
        c = rand_config();
      end
      reconfigure(c);
      run_random_phase($urandom_range(55, 85));
    end

    // Wait for the last results, then keep the clock running to catch any stray one.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
